// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define BOT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bot_pkg.sv =====
package bot_pkg;

	// Field widths
	localparam int POS_W   = 16;
	localparam int DIM_W   = 12;
	localparam int TILES_W = 8;
	localparam int EW_W    = TILES_W + DIM_W;
	localparam int CMP_W   = EW_W + 2;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [DIM_W-1:0] TILE_W_RESET = DIM_W'(32);
	localparam logic [DIM_W-1:0] TILE_H_RESET = DIM_W'(32);
	localparam logic REG_TILE_WIDTH  = 1'b0;
	localparam logic REG_TILE_HEIGHT = 1'b1;

	// Item kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic add;
		logic scan_start;
		logic scan_step;
		logic load_out;
	} bot_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} bot_stat_t;

endpackage

// ===== hdl/bot_in_if.sv =====
interface bot_in_if;
	import bot_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic        [TILES_W-1:0] tile_count;
	logic        [DIM_W-1:0]   box_width;
	logic        [DIM_W-1:0]   box_height;

	modport source (
		output valid, kind, pos_x, pos_y, tile_count, box_width, box_height,
		input  ready
	);

	modport sink (
		input  valid, kind, pos_x, pos_y, tile_count, box_width, box_height,
		output ready
	);

endinterface

// ===== hdl/bot_out_if.sv =====
interface bot_out_if;

	logic valid;
	logic ready;
	logic hit;
	logic full_res;

	modport source (
		output valid, hit, full_res,
		input  ready
	);

	modport sink (
		input  valid, hit, full_res,
		output ready
	);

endinterface

// ===== hdl/bot_regs.sv =====
module bot_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bot_pkg::PADDR_W-1:0]   paddr,
	input  logic [bot_pkg::PDATA_W-1:0]   pwdata,
	output logic [bot_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [bot_pkg::DIM_W-1:0]     tile_width,
	output logic [bot_pkg::DIM_W-1:0]     tile_height
);
	import bot_pkg::*;

	logic             wr_en;
	logic             reg_sel;
	logic [DIM_W-1:0] tile_width_q;
	logic [DIM_W-1:0] tile_height_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// Write a register on the access cycle of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= TILE_W_RESET;
			tile_height_q <= TILE_H_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TILE_WIDTH:  tile_width_q  <= pwdata[DIM_W-1:0];
				REG_TILE_HEIGHT: tile_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (reg_sel)
			REG_TILE_WIDTH:  prdata = PDATA_W'(tile_width_q);
			REG_TILE_HEIGHT: prdata = PDATA_W'(tile_height_q);
			default:         prdata = '0;
		endcase
	end

	assign tile_width  = tile_width_q;
	assign tile_height = tile_height_q;

endmodule

// ===== hdl/bot_ctrl.sv =====
module bot_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bot_pkg::bot_cmd_t  cmd,
	input  bot_pkg::bot_stat_t stat
);
	import bot_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_xfer;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture    = in_xfer;
				cmd.scan_start = in_xfer && (in_kind == KIND_QUERY);
			end
			ST_ADD:   cmd.add = 1'b1;
			ST_SCAN:  cmd.scan_step = !stat.scan_done;
			ST_DRAIN: ;
			ST_DONE:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	// Sequence one item at a time and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= (in_kind == KIND_QUERY) ? ST_SCAN : ST_ADD;
					end
				end
				ST_ADD: state_q <= ST_DONE;
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/bot_dp.sv =====
module bot_dp #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bot_pkg::bot_cmd_t                 cmd,
	output bot_pkg::bot_stat_t                stat,
	input  logic signed [bot_pkg::POS_W-1:0]  pos_x,
	input  logic signed [bot_pkg::POS_W-1:0]  pos_y,
	input  logic [bot_pkg::TILES_W-1:0]       tile_count,
	input  logic [bot_pkg::DIM_W-1:0]         box_width,
	input  logic [bot_pkg::DIM_W-1:0]         box_height,
	input  logic [bot_pkg::DIM_W-1:0]         tile_width,
	input  logic [bot_pkg::DIM_W-1:0]         tile_height,
	output logic                              hit,
	output logic                              full_res
);
	import bot_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TILES_W-1:0]      tiles;
	} entry_t;

	entry_t mem [MAX_ENTRIES];

	// Captured item
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic [TILES_W-1:0]      tiles_q;
	logic [DIM_W-1:0]        bw_q;
	logic [DIM_W-1:0]        bh_q;

	// Table and scan control
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             room;
	logic             hit_q;
	logic             full_q;
	logic             out_hit_q;
	logic             out_full_q;

	// Scan pipeline
	logic                    v_s1;
	entry_t                  ent_s1;
	logic                    v_s2;
	logic signed [POS_W-1:0] ex_s2;
	logic signed [POS_W-1:0] ey_s2;
	logic [EW_W-1:0]         ew_s2;

	// Overlap compare
	logic signed [CMP_W-1:0] qx0;
	logic signed [CMP_W-1:0] qx1;
	logic signed [CMP_W-1:0] qy0;
	logic signed [CMP_W-1:0] qy1;
	logic signed [CMP_W-1:0] ex0;
	logic signed [CMP_W-1:0] ex1;
	logic signed [CMP_W-1:0] ey0;
	logic signed [CMP_W-1:0] ey1;
	logic                    overlap;

	assign room = (count_q < CNT_MAX);

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			tiles_q <= tile_count;
			bw_q    <= box_width;
			bh_q    <= box_height;
		end
	end

	// Append an entry
	always_ff @(posedge clk) begin
		if (cmd.add && room) begin
			mem[count_q[IDX_W-1:0]] <= '{x: px_q, y: py_q, tiles: tiles_q};
		end
	end

	// Read one entry per scan step
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			ent_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	// Form the entry width in pixels
	always_ff @(posedge clk) begin
		ex_s2 <= ent_s1.x;
		ey_s2 <= ent_s1.y;
		ew_s2 <= EW_W'(ent_s1.tiles) * EW_W'(tile_width);
	end

	// Strict overlap: edges must cross, touching does not count
	always_comb begin
		qx0 = CMP_W'(px_q);
		qx1 = CMP_W'(px_q) + $signed({{(CMP_W-DIM_W){1'b0}}, bw_q});
		qy0 = CMP_W'(py_q);
		qy1 = CMP_W'(py_q) + $signed({{(CMP_W-DIM_W){1'b0}}, bh_q});
		ex0 = CMP_W'(ex_s2);
		ex1 = CMP_W'(ex_s2) + $signed({{(CMP_W-EW_W){1'b0}}, ew_s2});
		ey0 = CMP_W'(ey_s2);
		ey1 = CMP_W'(ey_s2) + $signed({{(CMP_W-DIM_W){1'b0}}, tile_height});
		overlap = (qx0 < ex1) && (qx1 > ex0) && (qy0 < ey1) && (qy1 > ey0);
	end

	// Count, scan pointer, pipeline valids and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			if (cmd.add) begin
				hit_q  <= 1'b0;
				full_q <= !room;
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				full_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (v_s2 && overlap) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q  <= hit_q;
			out_full_q <= full_q;
		end
	end

	assign stat.scan_done = (scan_q >= count_q);
	assign stat.pipe_busy = v_s1 || v_s2;
	assign hit            = out_hit_q;
	assign full_res       = out_full_q;

endmodule

// ===== hdl/box_overlap_table.sv =====
// Add: the item passes the add state, then the done state loads the result when the output is free.
// Query: the scan reads the N stored entries, one entry a cycle, then drains the pipeline before the
// done state loads the result; N is the stored entry count (at most MAX_ENTRIES).
// One item is in work at a time; a result not yet taken holds the next at its output load.
// arst_n clears the entry count, the control and the registers (tile width and
// height 32); table contents are not cleared.
module box_overlap_table #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bot_in_if.sink                      in_ch,
	bot_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bot_pkg::PADDR_W-1:0] paddr,
	input  logic [bot_pkg::PDATA_W-1:0] pwdata,
	output logic [bot_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bot_pkg::*;

	bot_cmd_t         cmd;
	bot_stat_t        stat;
	logic [DIM_W-1:0] tile_width;
	logic [DIM_W-1:0] tile_height;

	bot_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.tile_width  (tile_width),
		.tile_height (tile_height)
	);

	bot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bot_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.pos_x       (in_ch.pos_x),
		.pos_y       (in_ch.pos_y),
		.tile_count  (in_ch.tile_count),
		.box_width   (in_ch.box_width),
		.box_height  (in_ch.box_height),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.hit         (out_ch.hit),
		.full_res    (out_ch.full_res)
	);

endmodule

// ===== hdl/bot_checker.sv =====
`include "assert_macros.svh"

module bot_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_hit,
	input logic out_full
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// A waiting result holds until it is taken
	`BOT_ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped before transfer")

	// An item is either a query or an add, never both flags
	`BOT_ASSERT_ALWAYS(a_flags_excl, clk, out_valid |-> !(out_hit && out_full), "hit and full_res both set")

	// The block is busy in the cycle after an input transfer
	`BOT_ASSERT_RST(a_busy_after_in, clk, arst_n, in_xfer |=> !in_ready, "input taken while an item is in work")

	// No result appears in the cycle right after an input transfer
	`BOT_ASSERT_RST(a_no_early_out, clk, arst_n, in_xfer && !out_valid |=> !out_valid, "result appeared too early")

endmodule

bind box_overlap_table bot_checker u_bot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_hit   (out_ch.hit),
	.out_full  (out_ch.full_res)
);
